/* hdl/c6x_rel_patch_with_trampolines_core_defines.svh */
// Assertion macros for the C6000 relocation patcher.
`ifndef C6X_REL_PATCH_WITH_TRAMPOLINES_CORE_DEFINES_SVH
`define C6X_REL_PATCH_WITH_TRAMPOLINES_CORE_DEFINES_SVH

// Same-cycle implication.
`define C6XREL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define C6XREL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/c6xrel_pkg.sv */
`default_nettype none

package c6xrel_pkg;

    localparam int TRAMP_ENTRIES_DEF = 256;
    localparam int MAX_RSP           = 4;
    localparam int RSP_CNT_W         = 3;

    localparam logic [7:0] RT_ABS32      = 8'd1;
    localparam logic [7:0] RT_ABS16      = 8'd2;
    localparam logic [7:0] RT_ABS8       = 8'd3;
    localparam logic [7:0] RT_PCR_S21    = 8'd4;
    localparam logic [7:0] RT_PCR_S12    = 8'd5;
    localparam logic [7:0] RT_PCR_S10    = 8'd6;
    localparam logic [7:0] RT_DSBT_INDEX = 8'd24;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;

    localparam logic [0:0] CFG_TRAMP_BASE  = 1'b0;
    localparam logic [0:0] CFG_TRAMP_COUNT = 1'b1;

    localparam logic [31:0] OP_MVKL    = 32'h0051d1aa;
    localparam logic [31:0] OP_MVKH    = 32'h0051d1ea;
    localparam logic [31:0] OP_NOP     = 32'h0080a362;
    localparam logic [31:0] K_FIELD    = 32'h007fff80;
    localparam logic [31:0] DSBT_FIELD = 32'h007fff00;

    typedef struct packed {
        logic [7:0]  reloc_type;
        logic [31:0] place_addr;
        logic [31:0] place_word;
        logic [31:0] sym_value;
    } reloc_req_t;

    typedef struct packed {
        logic [31:0] write_addr;
        logic [31:0] write_data;
        logic [1:0]  write_size;
        logic        write_valid;
        logic        fail;
        logic        last;
    } reloc_rsp_t;

    typedef struct packed {
        reloc_rsp_t [MAX_RSP-1:0] rsp;
        logic [RSP_CNT_W-1:0]     count;
        logic                     alloc;
    } calc_out_t;

    function automatic reloc_rsp_t fail_rsp();
        reloc_rsp_t r;
        r = '0;
        r.fail = 1'b1;
        r.last = 1'b1;
        return r;
    endfunction

    function automatic reloc_rsp_t word_rsp(input logic [31:0] addr,
                                            input logic [31:0] data,
                                            input logic        last);
        reloc_rsp_t r;
        r.write_addr  = addr;
        r.write_data  = data;
        r.write_size  = SIZE_WORD;
        r.write_valid = 1'b1;
        r.fail        = 1'b0;
        r.last        = last;
        return r;
    endfunction

    // Word displacement from the 32-byte aligned place, arithmetic.
    function automatic logic [29:0] pcr_delta(input logic [31:0] place,
                                              input logic [31:0] dest);
        logic [31:0] diff;
        diff = dest - {place[31:5], 5'b0};
        return diff[31:2];
    endfunction

    function automatic logic pcr_fits(input logic [7:0]  rtype,
                                      input logic [29:0] delta);
        logic fit;
        case (rtype)
            RT_PCR_S21: fit = (&delta[29:20]) | ~(|delta[29:20]);
            RT_PCR_S12: fit = (&delta[29:11]) | ~(|delta[29:11]);
            default:    fit = (&delta[29:9])  | ~(|delta[29:9]);
        endcase
        return fit;
    endfunction

    function automatic logic [31:0] pcr_patch(input logic [7:0]  rtype,
                                              input logic [31:0] word,
                                              input logic [29:0] delta);
        logic [31:0] w;
        case (rtype)
            RT_PCR_S21: w = {word[31:28], delta[20:0], word[6:0]};
            RT_PCR_S12: w = {word[31:28], delta[11:0], word[15:0]};
            default:    w = {word[31:23], delta[9:0],  word[12:0]};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

/* hdl/c6xrel_calc.sv */
`default_nettype none

module c6xrel_calc
    import c6xrel_pkg::*;
#(
    parameter int TRAMP_ENTRIES = TRAMP_ENTRIES_DEF
)(
    input  wire reloc_req_t                              req,
    input  wire logic [31:0]                             tramp_base,
    input  wire logic [8:0]                              tramp_count,
    input  wire logic [$clog2(TRAMP_ENTRIES+1)-1:0]      next_free,
    output calc_out_t                                    res
);

    localparam int CNT_W = $clog2(TRAMP_ENTRIES + 1);
    localparam int AV_W  = (CNT_W > 9) ? CNT_W : 9;
    localparam int OFF_W = CNT_W + 4;
    localparam logic [AV_W-1:0] ENT_LIM = AV_W'(TRAMP_ENTRIES);

    logic             is_pcr;
    logic [29:0]      delta_sym;
    logic [29:0]      delta_ent;
    logic [AV_W-1:0]  nfe_ext;
    logic [AV_W-1:0]  cnt_ext;
    logic             have_entry;
    logic [OFF_W-1:0] ent_off;
    logic [31:0]      ent_addr;
    logic [31:0]      mvkl_word;
    logic [31:0]      mvkh_word;

    assign nfe_ext    = AV_W'(next_free);
    assign cnt_ext    = AV_W'(tramp_count);
    assign have_entry = (nfe_ext < cnt_ext) && (nfe_ext < ENT_LIM);

    // entry * 12
    assign ent_off  = {1'b0, next_free, 3'b000} + {2'b00, next_free, 2'b00};
    assign ent_addr = tramp_base + 32'(ent_off);

    assign delta_sym = pcr_delta(req.place_addr, req.sym_value);
    assign delta_ent = pcr_delta(req.place_addr, ent_addr);

    assign mvkl_word = (OP_MVKL & ~K_FIELD) | {9'b0, req.sym_value[15:0], 7'b0};
    assign mvkh_word = (OP_MVKH & ~K_FIELD) | {9'b0, req.sym_value[31:16], 7'b0};

    always_comb
    begin
        is_pcr    = 1'b0;
        res       = '0;
        res.count = RSP_CNT_W'(1);
        unique case (req.reloc_type) inside
            RT_ABS32:
            begin
                res.rsp[0] = word_rsp(req.place_addr, req.sym_value, 1'b1);
            end
            RT_ABS16:
            begin
                res.rsp[0] = word_rsp(req.place_addr, {16'b0, req.sym_value[15:0]}, 1'b1);
                res.rsp[0].write_size = SIZE_HALF;
            end
            RT_ABS8:
            begin
                res.rsp[0] = word_rsp(req.place_addr, {24'b0, req.sym_value[7:0]}, 1'b1);
                res.rsp[0].write_size = SIZE_BYTE;
            end
            RT_DSBT_INDEX:
            begin
                res.rsp[0] = word_rsp(req.place_addr, req.place_word & ~DSBT_FIELD, 1'b1);
            end
            RT_PCR_S21, RT_PCR_S12, RT_PCR_S10:
            begin
                is_pcr = 1'b1;
            end
            default:
            begin
                res.rsp[0] = fail_rsp();
            end
        endcase

        if (is_pcr)
        begin
            if (pcr_fits(req.reloc_type, delta_sym))
            begin
                res.rsp[0] = word_rsp(req.place_addr,
                                      pcr_patch(req.reloc_type, req.place_word, delta_sym),
                                      1'b1);
            end
            else if (!have_entry)
            begin
                res.rsp[0] = fail_rsp();
            end
            else
            begin
                res.alloc  = 1'b1;
                res.count  = RSP_CNT_W'(MAX_RSP);
                res.rsp[0] = word_rsp(ent_addr, mvkl_word, 1'b0);
                res.rsp[1] = word_rsp(ent_addr + 32'd4, mvkh_word, 1'b0);
                res.rsp[2] = word_rsp(ent_addr + 32'd8, OP_NOP, 1'b0);
                if (pcr_fits(req.reloc_type, delta_ent))
                    res.rsp[3] = word_rsp(req.place_addr,
                                          pcr_patch(req.reloc_type, req.place_word,
                                                    delta_ent),
                                          1'b1);
                else
                    res.rsp[3] = fail_rsp();
            end
        end
    end

endmodule

`default_nettype wire

/* hdl/c6x_rel_patch_with_trampolines_core.sv */
// C6000 REL relocation patcher. Each accepted request is one relocation and
// yields a burst of one to four results on the output channel, the final one
// marked last. Absolute, DSBT and in-range PC-relative relocations give one
// result, so a request can enter every cycle while the output is not stalled;
// an out-of-range PC-relative relocation claims the next trampoline entry, if
// one is free, and gives four results, which the single-result output port
// presents in turn. Each request is registered, then its results are loaded
// into the output buffer, from which the first result is presented. Program
// tramp_base and tramp_count while idle; the allocation pointer is cleared only by reset.
`default_nettype none

module c6x_rel_patch_with_trampolines_core
    import c6xrel_pkg::*;
#(
    parameter int TRAMP_ENTRIES = TRAMP_ENTRIES_DEF
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire reloc_req_t  in_req,
    output logic             out_valid,
    input  wire logic        out_stall,
    output reloc_rsp_t       out_rsp,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    localparam int CNT_W = $clog2(TRAMP_ENTRIES + 1);

    logic                 req_valid_reg, req_valid_next;
    reloc_req_t           req_reg;
    logic [31:0]          tramp_base_reg;
    logic [8:0]           tramp_count_reg;
    logic [CNT_W-1:0]     nfe_reg, nfe_next;
    reloc_rsp_t           buf_reg [MAX_RSP];
    reloc_rsp_t           buf_next [MAX_RSP];
    logic [RSP_CNT_W-1:0] rem_reg, rem_next;

    calc_out_t calc;
    logic      take;
    logic      load;
    logic      accept;

    c6xrel_calc #(
        .TRAMP_ENTRIES (TRAMP_ENTRIES)
    ) u_calc (
        .req         (req_reg),
        .tramp_base  (tramp_base_reg),
        .tramp_count (tramp_count_reg),
        .next_free   (nfe_reg),
        .res         (calc)
    );

    assign out_valid = (rem_reg != '0);
    assign out_rsp   = buf_reg[0];
    assign take      = out_valid && !out_stall;
    assign load      = req_valid_reg &&
                       ((rem_reg == '0) || (take && (rem_reg == RSP_CNT_W'(1))));
    assign in_stall  = req_valid_reg && !load;
    assign accept    = in_valid && !in_stall;

    always_comb
    begin
        req_valid_next = req_valid_reg;
        if (accept)
            req_valid_next = 1'b1;
        else if (load)
            req_valid_next = 1'b0;
    end

    always_comb
    begin
        nfe_next = nfe_reg;
        if (load && calc.alloc)
            nfe_next = nfe_reg + CNT_W'(1);
    end

    always_comb
    begin
        rem_next = rem_reg;
        for (int i = 0; i < MAX_RSP; i++)
            buf_next[i] = buf_reg[i];
        if (load)
        begin
            rem_next = calc.count;
            for (int i = 0; i < MAX_RSP; i++)
                buf_next[i] = calc.rsp[i];
        end
        else if (take)
        begin
            rem_next = rem_reg - RSP_CNT_W'(1);
            for (int i = 0; i < MAX_RSP - 1; i++)
                buf_next[i] = buf_reg[i+1];
            buf_next[MAX_RSP-1] = buf_reg[MAX_RSP-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg   <= 1'b0;
            nfe_reg         <= '0;
            rem_reg         <= '0;
            tramp_base_reg  <= '0;
            tramp_count_reg <= '0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            nfe_reg       <= nfe_next;
            rem_reg       <= rem_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_TRAMP_BASE:  tramp_base_reg  <= cfg_data;
                    CFG_TRAMP_COUNT: tramp_count_reg <= cfg_data[8:0];
                    default:         ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            req_reg <= in_req;
        for (int i = 0; i < MAX_RSP; i++)
            buf_reg[i] <= buf_next[i];
    end

endmodule

`default_nettype wire

/* hdl/c6xrel_checker.sv */
`default_nettype none
`include "c6x_rel_patch_with_trampolines_core_defines.svh"

module c6xrel_checker
    import c6xrel_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire reloc_rsp_t out_rsp
);

    `C6XREL_ASSERT_NOW(a_fail_clean, out_valid && out_rsp.fail, !out_rsp.write_valid && out_rsp.last && out_rsp.write_addr == 32'd0 && out_rsp.write_data == 32'd0 && out_rsp.write_size == SIZE_BYTE, "fail result carries write fields")
    `C6XREL_ASSERT_NOW(a_write_or_fail, out_valid, out_rsp.write_valid != out_rsp.fail, "result must be either a write or a failure")
    `C6XREL_ASSERT_NOW(a_size_code, out_valid && out_rsp.write_valid, out_rsp.write_size == SIZE_BYTE || out_rsp.write_size == SIZE_HALF || out_rsp.write_size == SIZE_WORD, "bad write size")
    `C6XREL_ASSERT_NEXT(a_burst_cont, out_valid && !out_stall && !out_rsp.last, out_valid, "trampoline burst broken")
    `C6XREL_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_rsp), "stalled result changed")

endmodule

bind c6x_rel_patch_with_trampolines_core c6xrel_checker u_c6xrel_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rsp   (out_rsp)
);

`default_nettype wire

/* verif/testbench.sv */
module testbench;
    import c6xrel_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int MAX_PRINTS  = 20;
    localparam logic [7:0] RT_NONE  = 8'd0;
    localparam logic [7:0] RT_UNDEF = 8'd7;
    localparam logic [7:0] RT_TOP   = 8'd255;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    reloc_req_t  in_req = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    reloc_rsp_t  out_rsp;
    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_index = CFG_TRAMP_BASE;
    logic [31:0] cfg_data = '0;

    reloc_req_t  reloc_queue[$];
    reloc_rsp_t  pending_writes[$];

    // model state
    logic [31:0] tramp_base_m = '0;
    logic [8:0]  tramp_count_m = '0;
    int          next_entry = 0;

    logic [31:0] cur_base = '0;
    logic        in_took = 1'b0;
    bit          calm = 1'b0;
    int          gap_left = 0;
    int          stall_left = 0;
    int          quiet_cycles = 0;
    int          errors = 0;
    int          relocs_done = 0;
    int          writes_checked = 0;
    int          tramps_built = 0;
    int          refusals = 0;

    c6x_rel_patch_with_trampolines_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_req    (in_req),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_rsp   (out_rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int field_bits(input logic [7:0] rtype);
        case (rtype)
            RT_PCR_S21: return 21;
            RT_PCR_S12: return 12;
            default:    return 10;
        endcase
    endfunction

    // Patches the displacement from the place rounded down to 32 bytes, in words, and returns whether it fits.
    function automatic bit pcr_try(input logic [7:0] rtype, input logic [31:0] place,
                                   input logic [31:0] word, input logic [31:0] dest,
                                   output logic [31:0] patched);
        int          nbits;
        int          sh;
        int          delta;
        logic [31:0] mask;
        nbits = field_bits(rtype);
        sh = (rtype == RT_PCR_S21) ? 7 : (rtype == RT_PCR_S12) ? 16 : 13;
        mask = (32'd1 << nbits) - 32'd1;
        delta = int'(dest - {place[31:5], 5'b0}) >>> 2;
        patched = (word & ~(mask << sh)) | ((32'(delta) & mask) << sh);
        return delta >= -(1 << (nbits - 1)) && delta < (1 << (nbits - 1));
    endfunction

    function automatic void queue_write(input logic [31:0] addr, input logic [31:0] data,
                                        input logic [1:0] size, input logic lst);
        reloc_rsp_t w;
        w.write_addr  = addr;
        w.write_data  = data;
        w.write_size  = size;
        w.write_valid = 1'b1;
        w.fail        = 1'b0;
        w.last        = lst;
        pending_writes.push_back(w);
    endfunction

    function automatic void queue_fail();
        reloc_rsp_t w;
        w = '0;
        w.fail = 1'b1;
        w.last = 1'b1;
        pending_writes.push_back(w);
        refusals++;
    endfunction

    function automatic void predict_writes(input reloc_req_t r);
        logic [31:0] patched;
        logic [31:0] entry;
        int          avail;
        case (r.reloc_type) inside
            RT_ABS32:      queue_write(r.place_addr, r.sym_value, SIZE_WORD, 1'b1);
            RT_ABS16:      queue_write(r.place_addr, {16'h0, r.sym_value[15:0]}, SIZE_HALF, 1'b1);
            RT_ABS8:       queue_write(r.place_addr, {24'h0, r.sym_value[7:0]}, SIZE_BYTE, 1'b1);
            RT_DSBT_INDEX: queue_write(r.place_addr, r.place_word & ~DSBT_FIELD, SIZE_WORD, 1'b1);
            RT_PCR_S21, RT_PCR_S12, RT_PCR_S10:
            begin
                if (pcr_try(r.reloc_type, r.place_addr, r.place_word, r.sym_value, patched))
                    queue_write(r.place_addr, patched, SIZE_WORD, 1'b1);
                else
                begin
                    avail = (tramp_count_m > TRAMP_ENTRIES_DEF) ? TRAMP_ENTRIES_DEF
                                                                : int'(tramp_count_m);
                    if (next_entry >= avail)
                        queue_fail();
                    else
                    begin
                        entry = tramp_base_m + 32'(next_entry * 12);
                        next_entry++;
                        tramps_built++;
                        queue_write(entry, (OP_MVKL & ~K_FIELD) |
                                    {9'h0, r.sym_value[15:0], 7'h0}, SIZE_WORD, 1'b0);
                        queue_write(entry + 32'd4, (OP_MVKH & ~K_FIELD) |
                                    ((r.sym_value >> 9) & K_FIELD), SIZE_WORD, 1'b0);
                        queue_write(entry + 32'd8, OP_NOP, SIZE_WORD, 1'b0);
                        if (pcr_try(r.reloc_type, r.place_addr, r.place_word, entry, patched))
                            queue_write(r.place_addr, patched, SIZE_WORD, 1'b1);
                        else
                            queue_fail();
                    end
                end
            end
            default: queue_fail();
        endcase
    endfunction

    function automatic reloc_req_t mk_req(input logic [7:0] rtype, input logic [31:0] place,
                                          input logic [31:0] word, input logic [31:0] sym);
        reloc_req_t r;
        r.reloc_type = rtype;
        r.place_addr = place;
        r.place_word = word;
        r.sym_value  = sym;
        return r;
    endfunction

    function automatic reloc_req_t random_reloc();
        reloc_req_t r;
        int         pick;
        int         lim;
        int         d;
        r = mk_req(RT_ABS32, $urandom, $urandom, $urandom);
        pick = $urandom_range(0, 99);
        if (pick < 8)
            r.reloc_type = 8'($urandom_range(0, 255));
        else if (pick < 14)
            r.reloc_type = RT_ABS32;
        else if (pick < 20)
            r.reloc_type = RT_ABS16;
        else if (pick < 26)
            r.reloc_type = RT_ABS8;
        else if (pick < 32)
            r.reloc_type = RT_DSBT_INDEX;
        else
        begin
            case ($urandom_range(0, 2))
                0:       r.reloc_type = RT_PCR_S21;
                1:       r.reloc_type = RT_PCR_S12;
                default: r.reloc_type = RT_PCR_S10;
            endcase
            lim = 1 << (field_bits(r.reloc_type) - 1);
            case ($urandom_range(0, 3))
                0: ;
                1:
                begin
                    case ($urandom_range(0, 3))
                        0:       d = lim - 1;
                        1:       d = lim;
                        2:       d = -lim;
                        default: d = -lim - 1;
                    endcase
                    r.sym_value = {r.place_addr[31:5], 5'b0} + 32'(d * 4) + $urandom_range(0, 3);
                end
                // place near the pool so the retry through a trampoline can land
                2: r.place_addr = cur_base + $urandom_range(0, 4095) - 32'd1024;
                default:
                begin
                    d = int'($urandom_range(0, 2 * lim - 1)) - lim;
                    r.sym_value = {r.place_addr[31:5], 5'b0} + 32'(d * 4) + $urandom_range(0, 3);
                end
            endcase
        end
        return r;
    endfunction

    function automatic int idle_len();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("mismatch at write %0d: %s got %h want %h", writes_checked, what, got, want);
    endtask

    task automatic set_reg(input logic [0:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_TRAMP_BASE: tramp_base_m = val;
            default:        tramp_count_m = val[8:0];
        endcase
    endtask

    task automatic drain();
        while (reloc_queue.size() != 0 || in_valid || pending_writes.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic new_pool(input logic [31:0] base, input logic [31:0] count);
        set_reg(CFG_TRAMP_BASE, base);
        set_reg(CFG_TRAMP_COUNT, count);
        cur_base = base;
    endtask

    // request driver
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_took))
        begin
            if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left--;
            end
            else if (reloc_queue.size() != 0)
            begin
                in_req   <= reloc_queue.pop_front();
                in_valid <= 1'b1;
                gap_left = idle_len();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result back-pressure
    always @(negedge clk)
    begin
        if ($urandom_range(0, 63) == 0)
            calm = !calm;
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            out_stall <= 1'b0;
            stall_left = idle_len();
        end
    end

    always @(posedge clk)
    begin : monitor
        reloc_rsp_t want;
        if (rst_n)
        begin
            in_took <= in_valid && !in_stall;
            if (in_valid && !in_stall)
            begin
                predict_writes(in_req);
                relocs_done++;
            end
            if (out_valid && !out_stall)
            begin
                if (pending_writes.size() == 0)
                    report_mismatch("result with nothing pending, addr", out_rsp.write_addr, '0);
                else
                begin
                    want = pending_writes.pop_front();
                    if (out_rsp.write_addr !== want.write_addr)
                        report_mismatch("write_addr", out_rsp.write_addr, want.write_addr);
                    if (out_rsp.write_data !== want.write_data)
                        report_mismatch("write_data", out_rsp.write_data, want.write_data);
                    if (out_rsp.write_size !== want.write_size)
                        report_mismatch("write_size", out_rsp.write_size, want.write_size);
                    if (out_rsp.write_valid !== want.write_valid)
                        report_mismatch("write_valid", out_rsp.write_valid, want.write_valid);
                    if (out_rsp.fail !== want.fail)
                        report_mismatch("fail", out_rsp.fail, want.fail);
                    if (out_rsp.last !== want.last)
                        report_mismatch("last", out_rsp.last, want.last);
                end
                writes_checked++;
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("no handshake for %0d cycles, %0d writes still pending",
                         quiet_cycles, pending_writes.size());
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset pool: base 0, no entries
        reloc_queue.push_back(mk_req(RT_ABS32, 32'hffffffff, 32'h0, 32'hffffffff));
        reloc_queue.push_back(mk_req(RT_ABS16, 32'h0, 32'hffffffff, 32'hdeadbeef));
        reloc_queue.push_back(mk_req(RT_ABS8, 32'h1, 32'h0, 32'h12345680));
        reloc_queue.push_back(mk_req(RT_DSBT_INDEX, 32'h100, 32'hffffffff, 32'h0));
        reloc_queue.push_back(mk_req(RT_NONE, 32'h1234, 32'h5678, 32'h9abc));
        reloc_queue.push_back(mk_req(RT_TOP, 32'hffffffff, 32'hffffffff, 32'hffffffff));
        reloc_queue.push_back(mk_req(RT_UNDEF, 32'h40, 32'h0, 32'h80));
        reloc_queue.push_back(mk_req(RT_PCR_S21, 32'h1003, 32'hffffffff, 32'h00400fff));
        reloc_queue.push_back(mk_req(RT_PCR_S12, 32'h80000010, 32'h0, 32'h7fffe000));
        reloc_queue.push_back(mk_req(RT_PCR_S10, 32'hffffffff, 32'ha5a5a5a5, 32'hffffffe0));
        reloc_queue.push_back(mk_req(RT_PCR_S10, 32'h20, 32'hffffffff, 32'h820));
        reloc_queue.push_back(mk_req(RT_PCR_S21, 32'h40000000, 32'h0, 32'h3fbffffc));
        drain();

        // two-entry pool that wraps past the top of memory
        new_pool(32'hfffffff4, 32'd2);
        reloc_queue.push_back(mk_req(RT_PCR_S21, 32'hffffff00, 32'hffffffff, 32'h40000000));
        reloc_queue.push_back(mk_req(RT_PCR_S10, 32'h10000000, 32'h0, 32'h20000000));
        reloc_queue.push_back(mk_req(RT_PCR_S12, 32'h0, 32'h12345678, 32'h80000000));
        drain();

        new_pool({30'($urandom_range(0, 32'h3fffffff)), 2'b00}, 32'd511);
        repeat (45) reloc_queue.push_back(random_reloc());
        drain();

        new_pool(32'h0, 32'd256);
        repeat (40) reloc_queue.push_back(random_reloc());
        drain();

        // pool already used up
        new_pool(32'hfffffffc, 32'd1);
        repeat (30) reloc_queue.push_back(random_reloc());
        drain();

        repeat (10) @(posedge clk);
        $display("%0d relocations over five pool settings, %0d writes compared", relocs_done,
                 writes_checked);
        $display("%0d trampolines built, %0d relocations refused, %0d mismatches", tramps_built,
                 refusals, errors);
        if (errors == 0 && pending_writes.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
